### sv/rnt_pkg.sv
// ----------------------------------------------------------------------------
// rnt_pkg: shared types and constants of the radio neighbour table
// Token, report and write-back structures of the slot cell chain.
// ----------------------------------------------------------------------------
package rnt_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int SLOT_IDX_W    = 4;
  localparam int ID_W          = 32;
  localparam int RSSI_W        = 8;
  localparam int CNT_W         = 16;
  localparam int TOT_W         = 20;
  localparam int AGE_W         = 8;
  localparam int LIMIT_W       = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_DATA_W     = 104;
  localparam int OUT_DATA_W    = 128;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_PAIR_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0]       STALE_LIMIT_RST = 8'd4;
  localparam logic signed [RSSI_W-1:0] RSSI_EMPTY      = -8'sd127;
  localparam logic signed [RSSI_W-1:0] RSSI_MAX        = 8'sd127;

  typedef struct packed {
    logic                  act;
    logic                  tick;
    logic [ID_W-1:0]       id;
    logic [RSSI_W-1:0]     rssi;
    logic [CNT_W-1:0]      retries;
    logic [CNT_W-1:0]      link_errors;
    logic [CNT_W-1:0]      resets;
    logic [CNT_W-1:0]      dropped;
    logic                  matched;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [RSSI_W-1:0]     lo_rssi;
    logic [SLOT_IDX_W-1:0] lo_idx;
    logic                  linked;
    logic [TOT_W-1:0]      tot_retries;
    logic [TOT_W-1:0]      tot_link_errors;
    logic [TOT_W-1:0]      tot_dropped;
    logic [TOT_W-1:0]      tot_resets;
  } carry_t;

  typedef struct packed {
    logic                  valid;
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
    logic [RSSI_W-1:0]     rssi;
    logic                  last;
    logic                  linked;
    logic [TOT_W-1:0]      tot_retries;
    logic [TOT_W-1:0]      tot_link_errors;
    logic [TOT_W-1:0]      tot_dropped;
    logic [TOT_W-1:0]      tot_resets;
  } report_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
    logic [RSSI_W-1:0]     rssi;
    logic [CNT_W-1:0]      retries;
    logic [CNT_W-1:0]      link_errors;
    logic [CNT_W-1:0]      resets;
    logic [CNT_W-1:0]      dropped;
  } wr_t;

endpackage

### sv/rnt_cell.sv
// ----------------------------------------------------------------------------
// rnt_cell: one slot of the radio neighbour table
// Holds one neighbour entry, searches or ages it as the token passes, and
// hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module rnt_cell
  import rnt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SLOT_POS  = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [ID_W-1:0]    own_pair_id,
  input  logic [LIMIT_W-1:0] stale_limit,
  input  carry_t             carry_in,
  input  wr_t                wr,
  output carry_t             carry_out,
  output report_t            report
);

  localparam logic [SLOT_IDX_W-1:0] POS_L  = SLOT_IDX_W'(SLOT_POS);
  localparam logic                  LAST_L = (SLOT_POS == NUM_SLOTS - 1);

  logic [ID_W-1:0]   id_r,   id_nxt;
  logic [RSSI_W-1:0] rssi_r, rssi_nxt;
  logic [CNT_W-1:0]  ret_r,  ret_nxt;
  logic [CNT_W-1:0]  err_r,  err_nxt;
  logic [CNT_W-1:0]  rst_r,  rst_nxt;
  logic [CNT_W-1:0]  drp_r,  drp_nxt;
  logic [AGE_W-1:0]  age_r,  age_nxt;
  carry_t            carry_r, carry_nxt;

  logic [AGE_W-1:0]  age_inc;
  logic              stale;
  logic              live;

  assign age_inc = age_r + AGE_W'(1);
  assign stale   = age_inc > stale_limit;
  assign live    = (own_pair_id != '0) && (id_r == own_pair_id) && !stale &&
                   ($signed(rssi_r) > RSSI_EMPTY);

  always_comb begin
    carry_nxt = carry_in;
    if (!carry_in.tick) begin
      if (!carry_in.matched && (carry_in.id == id_r)) begin
        carry_nxt.matched   = 1'b1;
        carry_nxt.match_idx = POS_L;
      end
      if ($signed(rssi_r) < $signed(carry_in.lo_rssi)) begin
        carry_nxt.lo_rssi = rssi_r;
        carry_nxt.lo_idx  = POS_L;
      end
    end else if (live) begin
      carry_nxt.linked          = 1'b1;
      carry_nxt.tot_retries     = carry_in.tot_retries + TOT_W'(ret_r);
      carry_nxt.tot_link_errors = carry_in.tot_link_errors + TOT_W'(err_r);
      carry_nxt.tot_dropped     = carry_in.tot_dropped + TOT_W'(drp_r);
      carry_nxt.tot_resets      = carry_in.tot_resets + TOT_W'(rst_r);
    end
  end

  always_comb begin
    report       = '0;
    report.valid = carry_in.act && carry_in.tick;
    if (report.valid) begin
      report.idx  = POS_L;
      report.id   = id_r;
      report.rssi = rssi_r;
      report.last = LAST_L;
      if (LAST_L) begin
        report.linked          = carry_nxt.linked;
        report.tot_retries     = carry_nxt.tot_retries;
        report.tot_link_errors = carry_nxt.tot_link_errors;
        report.tot_dropped     = carry_nxt.tot_dropped;
        report.tot_resets      = carry_nxt.tot_resets;
      end
    end
  end

  always_comb begin
    id_nxt   = id_r;
    rssi_nxt = rssi_r;
    ret_nxt  = ret_r;
    err_nxt  = err_r;
    rst_nxt  = rst_r;
    drp_nxt  = drp_r;
    age_nxt  = age_r;
    if (adv && carry_in.act && carry_in.tick) begin
      if (stale) begin
        id_nxt   = '0;
        rssi_nxt = RSSI_EMPTY;
        ret_nxt  = '0;
        err_nxt  = '0;
        rst_nxt  = '0;
        drp_nxt  = '0;
        age_nxt  = '0;
      end else begin
        age_nxt = age_inc;
      end
    end
    if (wr.en && (wr.idx == POS_L)) begin
      id_nxt   = wr.id;
      rssi_nxt = wr.rssi;
      ret_nxt  = wr.retries;
      err_nxt  = wr.link_errors;
      rst_nxt  = wr.resets;
      drp_nxt  = wr.dropped;
      age_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '0;
      rssi_r <= RSSI_EMPTY;
      ret_r  <= '0;
      err_r  <= '0;
      rst_r  <= '0;
      drp_r  <= '0;
      age_r  <= '0;
    end else begin
      id_r   <= id_nxt;
      rssi_r <= rssi_nxt;
      ret_r  <= ret_nxt;
      err_r  <= err_nxt;
      rst_r  <= rst_nxt;
      drp_r  <= drp_nxt;
      age_r  <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.act <= 1'b0;
    end else if (adv) begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;

endmodule

### sv/radio_neighbor_table.sv
// ----------------------------------------------------------------------------
// radio_neighbor_table: neighbour radio table with periodic status report
// Slot cells in a chain; a token walks it one slot per cycle when not stalled.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A transaction enters a token register and
// then walks the NUM_SLOTS slot cells at one cell per cycle unless the output
// stalls; a status packet is written back to its chosen slot once the token
// leaves the last cell, so in_tready stays low while the token is in the
// token register or in any cell, and the next transaction is accepted only
// once it has left. A tick emits one result per cycle as it passes each cell,
// so output back-pressure stretches the walk by the stalled cycles. Totals and
// link state appear only on the tlast result.
module radio_neighbor_table
  import rnt_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sender_id, rssi, retries, link_errors, resets, dropped
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot_index, slot_id, slot_rssi, link_connected, total_retries,
  // total_link_errors, total_dropped, total_resets, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [ID_W-1:0]    own_pair_id_r;
  logic [LIMIT_W-1:0] stale_limit_r;

  carry_t             entry_r, entry_nxt;
  carry_t             chain [NUM_SLOTS+1];
  report_t            reps  [NUM_SLOTS];
  report_t            rep_any;
  report_t            out_r;
  logic               out_valid_r;
  logic [NUM_SLOTS:0] acts;
  logic               busy;
  logic               adv;
  logic               in_acc;
  wr_t                wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pair_id_r <= '0;
      stale_limit_r <= STALE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OWN_PAIR_ID: own_pair_id_r <= cfg_wdata[ID_W-1:0];
        REG_STALE_LIMIT: stale_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign busy      = |acts;
  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    entry_nxt             = '0;
    entry_nxt.act         = 1'b1;
    entry_nxt.tick        = in_tuser;
    entry_nxt.id          = in_tdata[31:0];
    entry_nxt.rssi        = in_tdata[39:32];
    entry_nxt.retries     = in_tdata[55:40];
    entry_nxt.link_errors = in_tdata[71:56];
    entry_nxt.resets      = in_tdata[87:72];
    entry_nxt.dropped     = in_tdata[103:88];
    entry_nxt.lo_rssi     = RSSI_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.act <= 1'b0;
    end else if (in_acc) begin
      entry_r <= entry_nxt;
    end else if (adv) begin
      entry_r.act <= 1'b0;
    end
  end

  assign chain[0] = entry_r;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    rnt_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_POS  (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .own_pair_id (own_pair_id_r),
      .stale_limit (stale_limit_r),
      .carry_in    (chain[k]),
      .wr          (wr),
      .carry_out   (chain[k+1]),
      .report      (reps[k])
    );
  end

  always_comb begin
    for (int k = 0; k <= NUM_SLOTS; k++) begin
      acts[k] = chain[k].act;
    end
  end

  always_comb begin
    rep_any = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      rep_any = rep_any | reps[k];
    end
  end

  always_comb begin
    wr             = '0;
    wr.en          = chain[NUM_SLOTS].act && !chain[NUM_SLOTS].tick;
    wr.id          = chain[NUM_SLOTS].id;
    wr.rssi        = chain[NUM_SLOTS].rssi;
    wr.retries     = chain[NUM_SLOTS].retries;
    wr.link_errors = chain[NUM_SLOTS].link_errors;
    wr.resets      = chain[NUM_SLOTS].resets;
    wr.dropped     = chain[NUM_SLOTS].dropped;
    if (chain[NUM_SLOTS].matched) begin
      wr.idx = chain[NUM_SLOTS].match_idx;
    end else if (chain[NUM_SLOTS].id == own_pair_id_r) begin
      wr.idx = '0;
    end else begin
      wr.idx = chain[NUM_SLOTS].lo_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rep_any.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= rep_any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {3'b000, out_r.tot_resets, out_r.tot_dropped,
                       out_r.tot_link_errors, out_r.tot_retries, out_r.linked,
                       out_r.rssi, out_r.id, out_r.idx};

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(acts))
    else $error("more than one token in the slot chain");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == SLOT_IDX_W'(NUM_SLOTS - 1))
    else $error("tlast result does not report the final slot");

  a_zero_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[124:44] == '0)
    else $error("totals present on a result other than the last");

  a_no_write_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !rep_any.valid)
    else $error("slot write-back overlaps a tick report");

endmodule

### test/tb_radio_neighbor_table.sv
// ----------------------------------------------------------------------------
// tb_radio_neighbor_table: self-checking bench for the neighbour radio table
// Feeds status packets and ticks through the input stream with random gaps,
// mirrors the slot table in a local predictor, and compares every tick report
// field by field. Register settings change only while the table is idle.
// ----------------------------------------------------------------------------
module tb_radio_neighbor_table;
  import rnt_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int SETTLE      = NUM_SLOTS + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 100000;

  typedef enum logic {
    CMD_STATUS = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef struct {
    cmd_t                     cmd;
    logic [ID_W-1:0]          id;
    logic signed [RSSI_W-1:0] rssi;
    logic [CNT_W-1:0]         retries;
    logic [CNT_W-1:0]         link_errors;
    logic [CNT_W-1:0]         resets;
    logic [CNT_W-1:0]         dropped;
  } radio_item_t;

  typedef struct {
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
    logic [RSSI_W-1:0]     rssi;
    logic                  last;
    logic                  linked;
    logic [TOT_W-1:0]      t_ret;
    logic [TOT_W-1:0]      t_err;
    logic [TOT_W-1:0]      t_drop;
    logic [TOT_W-1:0]      t_rst;
  } slot_report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // predictor copy of the table and its registers
  logic [ID_W-1:0]          pair_id;
  logic [LIMIT_W-1:0]       stale_lim;
  logic [ID_W-1:0]          nb_id    [NUM_SLOTS];
  logic signed [RSSI_W-1:0] nb_rssi  [NUM_SLOTS];
  logic [CNT_W-1:0]         nb_retry [NUM_SLOTS];
  logic [CNT_W-1:0]         nb_err   [NUM_SLOTS];
  logic [CNT_W-1:0]         nb_rst   [NUM_SLOTS];
  logic [CNT_W-1:0]         nb_drop  [NUM_SLOTS];
  logic [AGE_W-1:0]         nb_age   [NUM_SLOTS];

  radio_item_t  pending_q[$];
  slot_report_t report_q[$];
  radio_item_t  cur_item;
  logic [ID_W-1:0] id_pool[4];

  int  items_queued   = 0;
  int  items_taken    = 0;
  int  ticks_queued   = 0;
  int  reports_seen   = 0;
  int  mismatches     = 0;
  int  settings_tried = 1;
  int  send_gap       = 0;
  int  recv_stall     = 0;
  bit  idle_on        = 1'b1;
  bit  hold_req       = 1'b0;
  bit  drained;

  radio_neighbor_table #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void clear_slot(int s);
    nb_id[s]    = '0;
    nb_rssi[s]  = RSSI_EMPTY;
    nb_retry[s] = '0;
    nb_err[s]   = '0;
    nb_rst[s]   = '0;
    nb_drop[s]  = '0;
    nb_age[s]   = '0;
  endfunction

  function automatic void absorb_status(radio_item_t it);
    int                       tgt;
    logic signed [RSSI_W-1:0] lo;
    tgt = -1;
    for (int s = 0; s < NUM_SLOTS; s++)
      if (tgt < 0 && nb_id[s] == it.id) tgt = s;
    if (tgt < 0) begin
      tgt = 0;
      if (it.id != pair_id) begin
        lo = nb_rssi[0];
        for (int s = 1; s < NUM_SLOTS; s++) begin
          if (nb_rssi[s] < lo) begin
            lo  = nb_rssi[s];
            tgt = s;
          end
        end
      end
    end
    nb_id[tgt]    = it.id;
    nb_rssi[tgt]  = it.rssi;
    nb_retry[tgt] = it.retries;
    nb_err[tgt]   = it.link_errors;
    nb_rst[tgt]   = it.resets;
    nb_drop[tgt]  = it.dropped;
    nb_age[tgt]   = '0;
  endfunction

  function automatic void age_and_report();
    slot_report_t     rep;
    logic [TOT_W-1:0] sr, se, sd, sx;
    logic             lk;
    sr = '0;
    se = '0;
    sd = '0;
    sx = '0;
    lk = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      rep.idx  = SLOT_IDX_W'(s);
      rep.id   = nb_id[s];
      rep.rssi = nb_rssi[s];
      rep.last = (s == NUM_SLOTS - 1);
      nb_age[s] = nb_age[s] + 1'b1;
      if (nb_age[s] > stale_lim) clear_slot(s);
      if (pair_id != '0 && nb_id[s] == pair_id && nb_rssi[s] > RSSI_EMPTY) begin
        sr = sr + nb_retry[s];
        se = se + nb_err[s];
        sd = sd + nb_drop[s];
        sx = sx + nb_rst[s];
        lk = 1'b1;
      end
      rep.linked = rep.last ? lk : 1'b0;
      rep.t_ret  = rep.last ? sr : '0;
      rep.t_err  = rep.last ? se : '0;
      rep.t_drop = rep.last ? sd : '0;
      rep.t_rst  = rep.last ? sx : '0;
      report_q.push_back(rep);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [RSSI_W-1:0] pick_rssi();
    case ($urandom_range(0, 11))
      0:       return 8'h80;
      1:       return RSSI_EMPTY;
      2:       return RSSI_MAX;
      default: return RSSI_W'($urandom);
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 19))
      0, 1:    return '1;
      2:       return '0;
      default: return CNT_W'($urandom);
    endcase
  endfunction

  task automatic push_item(cmd_t cmd, logic [ID_W-1:0] id, logic [RSSI_W-1:0] rssi,
                           logic [CNT_W-1:0] ret, logic [CNT_W-1:0] le,
                           logic [CNT_W-1:0] rs, logic [CNT_W-1:0] dr);
    radio_item_t it;
    it.cmd         = cmd;
    it.id          = id;
    it.rssi        = rssi;
    it.retries     = ret;
    it.link_errors = le;
    it.resets      = rs;
    it.dropped     = dr;
    pending_q.push_back(it);
    items_queued++;
    if (cmd == CMD_TICK) ticks_queued++;
  endtask

  task automatic push_tick();
    push_item(CMD_TICK, $urandom, pick_rssi(), pick_count(), pick_count(),
              pick_count(), pick_count());
  endtask

  task automatic queue_random(int n, int tick_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct)
        push_tick();
      else if (r < 90)
        push_item(CMD_STATUS, ($urandom_range(0, 5) == 0) ? pair_id :
                  id_pool[$urandom_range(0, 3)], pick_rssi(), pick_count(),
                  pick_count(), pick_count(), pick_count());
      else
        push_item(CMD_STATUS, $urandom, pick_rssi(), pick_count(), pick_count(),
                  pick_count(), pick_count());
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_OWN_PAIR_ID: pair_id   = val;
      REG_STALE_LIMIT: stale_lim = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(logic [ID_W-1:0] pid, logic [LIMIT_W-1:0] lim);
    write_reg(REG_OWN_PAIR_ID, pid);
    write_reg(REG_STALE_LIMIT, CFG_DATA_W'(lim));
    id_pool[0] = '0;
    id_pool[1] = $urandom;
    id_pool[2] = $urandom;
    id_pool[3] = $urandom;
    settings_tried++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    while ((items_taken != items_queued || report_q.size() != 0) && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    drained = (n < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_items
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        if (cur_item.cmd == CMD_TICK) age_and_report();
        else absorb_status(cur_item);
        items_taken++;
        send_gap = pick_gap();
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          in_tuser <= cur_item.cmd;
          in_tdata <= {cur_item.dropped, cur_item.resets, cur_item.link_errors,
                       cur_item.retries, cur_item.rssi, cur_item.id};
          nv = 1'b1;
        end
      end
      in_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin : watch_reports
    slot_report_t exp_rep;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report slot %0d expected none", $time, out_tdata[3:0]);
          mismatches++;
        end else begin
          exp_rep = report_q.pop_front();
          check_field("slot_index", exp_rep.idx, out_tdata[3:0]);
          check_field("slot_id", exp_rep.id, out_tdata[35:4]);
          check_field("slot_rssi", exp_rep.rssi, out_tdata[43:36]);
          check_field("is_last", exp_rep.last, out_tlast);
          check_field("link_connected", exp_rep.linked, out_tdata[44]);
          check_field("total_retries", exp_rep.t_ret, out_tdata[64:45]);
          check_field("total_link_errors", exp_rep.t_err, out_tdata[84:65]);
          check_field("total_dropped", exp_rep.t_drop, out_tdata[104:85]);
          check_field("total_resets", exp_rep.t_rst, out_tdata[124:105]);
        end
      end
      if (hold_req) begin
        recv_stall = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    pair_id   = '0;
    stale_lim = STALE_LIMIT_RST;
    for (int s = 0; s < NUM_SLOTS; s++) clear_slot(s);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: no pairing, stale limit of four, so a slot clears on the fifth tick after its last update
    push_item(CMD_STATUS, '1, RSSI_MAX, '1, '1, '1, '1);
    push_item(CMD_STATUS, '0, 8'h80, '0, '0, '0, '0);
    push_item(CMD_STATUS, 32'h1234_5678, RSSI_EMPTY, 16'h00ff, 16'hff00, 16'h5a5a, 16'ha5a5);
    push_item(CMD_STATUS, 32'h0000_0042, 8'h00, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
    push_tick();
    push_item(CMD_STATUS, '1, 8'hf0, 16'h0010, 16'h0020, 16'h0030, 16'h0040);
    push_item(CMD_STATUS, 32'h0000_0077, 8'h05, '1, '0, '1, '0);
    for (int i = 0; i < 5; i++) push_tick();
    drain();

    // paired radio takes slot 0 and feeds the totals
    set_regs(32'ha5a5_0001, 8'd254);
    push_item(CMD_STATUS, 32'h0000_0101, 8'd50, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    push_item(CMD_STATUS, 32'ha5a5_0001, -8'sd100, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
    push_tick();
    push_item(CMD_STATUS, 32'ha5a5_0001, RSSI_EMPTY, '1, '1, '1, '1);
    push_tick();
    push_item(CMD_STATUS, 32'ha5a5_0001, RSSI_MAX, '1, '1, '1, '1);
    push_item(CMD_STATUS, '0, 8'h80, '1, '1, '1, '1);
    push_tick();
    drain();

    set_regs('1, 8'd0);
    queue_random(40, 25);
    drain();

    idle_on = 1'b0;
    set_regs('0, 8'd254);
    queue_random(40, 25);
    drain();
    idle_on = 1'b1;

    set_regs($urandom, LIMIT_W'($urandom_range(1, 6)));
    push_tick();
    hold_req = 1'b1;
    queue_random(60, 30);
    drain();

    set_regs($urandom, 8'd2);
    queue_random(60, 25);
    drain();

    if (!drained) begin
      $display("%0t: %0d reports still outstanding at the end", $time, report_q.size());
      mismatches++;
    end
    $display("Ran %0d transactions (%0d ticks) over %0d register settings.",
             items_taken, ticks_queued, settings_tried);
    $display("Checked %0d tick reports, including a long output hold-off.", reports_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/rnt_pkg.sv
sv/rnt_cell.sv
sv/radio_neighbor_table.sv
test/tb_radio_neighbor_table.sv
